>>> rtl/core/imu_sample_frame_generator_core_assert.svh
// assertion macros for the port checker of the core
`ifndef IMU_SAMPLE_FRAME_GENERATOR_CORE_ASSERT_SVH
`define IMU_SAMPLE_FRAME_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ISFG_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isfg assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ISFG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isfg assertion failed");

`endif

>>> rtl/core/isfg_pkg.sv
package isfg_pkg;

  localparam int CODE_BITS = 14;
  localparam int DIV_W     = 32;
  localparam int MV_W      = 13;
  localparam int COUNT_W   = 4;
  localparam int XY_W      = 15;
  localparam int Z_W       = 14;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 15;
  localparam int ACC_W     = 16;
  localparam int ACCZ_W    = 15;

  localparam logic [DIV_W-1:0] LCG_MUL   = 32'd1664525;
  localparam logic [DIV_W-1:0] LCG_ADD   = 32'd1013904223;
  localparam logic [DIV_W-1:0] GEN_RESET = 32'hDEADBEEF;
  localparam logic [DIV_W-1:0] FULL_SCALE_MV = 32'd5000;
  localparam logic [ACCZ_W-1:0] ONE_G    = 15'd16384;

  // floor(x / 5000) as ((x >> 3) * TEMP_RECIP) >> 36, exact for x below 2^29
  localparam int TEMP_PRE_SHIFT = 3;
  localparam int TEMP_RECIP_W   = 27;
  localparam logic [TEMP_RECIP_W-1:0] TEMP_RECIP = 27'd109951163;
  localparam int TEMP_SHIFT     = 36;

  localparam logic [XY_W-1:0] XY_RANGE_RESET = 15'd16384;
  localparam logic [Z_W-1:0]  Z_RANGE_RESET  = 14'd1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_XY_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_RANGE  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/core/isfg_if.sv
// transfer word: byte count and analog reading
interface isfg_in_if;
  logic                           valid;
  logic                           ready;
  logic [isfg_pkg::COUNT_W-1:0]   transfer_count;
  logic [isfg_pkg::MV_W-1:0]      analog_millivolts;

  modport source (output valid, output transfer_count, output analog_millivolts,
                  input ready);
  modport sink   (input valid, input transfer_count, input analog_millivolts,
                  output ready);
endinterface

// reply word: temperature code and three axes
interface isfg_out_if #(
  parameter int CODE_BITS = isfg_pkg::CODE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [CODE_BITS-1:0]          temperature_code;
  logic signed [isfg_pkg::ACC_W-1:0] accel_x;
  logic signed [isfg_pkg::ACC_W-1:0] accel_y;
  logic [isfg_pkg::ACCZ_W-1:0]   accel_z;

  modport source (output valid, output temperature_code, output accel_x,
                  output accel_y, output accel_z, input ready);
  modport sink   (input valid, input temperature_code, input accel_x,
                  input accel_y, input accel_z, output ready);
endinterface

>>> rtl/core/isfg_divider.sv
// restoring divider, one quotient bit per cycle
module isfg_divider #(
  parameter int W = isfg_pkg::DIV_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isfg_pkg::div_req_t req_i,
  output isfg_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(W);

  logic [W:0]       rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [W:0] shifted;
  logic [W:0] diff;

  always_comb begin
    shifted = {rem_q[W-1:0], quo_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (!diff[W]) begin
      rem_d = diff;
      quo_d = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_d = shifted;
      quo_d = {quo_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[W-1:0];

endmodule

>>> rtl/core/imu_sample_frame_generator_core.sv
// channel    dir  word                                              handshake
// in_i       in   transfer_count, analog_millivolts                 valid/ready
// out_o      out  temperature_code, accel_x, accel_y, accel_z       valid/ready
// cfg        in   cfg_we_i, cfg_index_i, cfg_data_i                 write enable only
//
// a word with a nonzero count has its reply built in this order: the temperature
// code by reciprocal multiply, then per axis one generator step and a pass of the
// shared restoring divider (32 steps and a done strobe), then the load into the
// output register; the next word can be taken as soon as that reply is shown
// a word with a zero count is taken and leaves no trace
// rst_ni is asynchronous and active low; the generator returns to 0xdeadbeef
// and both noise ranges to their defaults
// a finished reply waits in the output register; the sequencer holds in done
// only while an older reply has not yet been taken
module imu_sample_frame_generator_core #(
  parameter int CODE_BITS = isfg_pkg::CODE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  isfg_in_if.sink                           in_i,
  isfg_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [isfg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [isfg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int DW      = isfg_pkg::DIV_W;
  localparam int PROD_W  = isfg_pkg::MV_W + CODE_BITS;
  localparam int TQ_W    = PROD_W - isfg_pkg::TEMP_PRE_SHIFT;
  localparam int TPROD_W = TQ_W + isfg_pkg::TEMP_RECIP_W;
  localparam logic [DW-1:0] FULL = DW'((64'd1 << CODE_BITS) - 64'd1);

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TEMP  = 5'b00010,
    S_STEP  = 5'b00100,
    S_NOISE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // which axis the current noise pass serves
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  state_e state_q, state_d;
  axis_e  axis_q;

  logic [DW-1:0] gen_q;
  logic [DW-1:0] gen_next;

  logic [isfg_pkg::XY_W-1:0] xy_range_q;
  logic [isfg_pkg::Z_W-1:0]  z_range_q;

  // scaled reading divided by 8, and whether it is at or past full scale
  logic [TQ_W-1:0]                 temp_q;
  logic                            temp_sat_q;

  // staged reply
  logic [CODE_BITS-1:0]            code_q;
  logic [isfg_pkg::ACC_W-1:0]      x_q, y_q;
  logic [isfg_pkg::ACCZ_W-1:0]     z_q;

  // output register
  logic                            out_valid_q;
  logic [CODE_BITS-1:0]            out_code_q;
  logic [isfg_pkg::ACC_W-1:0]      out_x_q, out_y_q;
  logic [isfg_pkg::ACCZ_W-1:0]     out_z_q;

  isfg_pkg::div_req_t div_req;
  isfg_pkg::div_rsp_t div_rsp;

  logic              in_fire;
  logic              take_word;
  logic              load_out;
  logic [PROD_W-1:0] scaled_mv;
  logic [TPROD_W-1:0] temp_prod;
  logic [CODE_BITS-1:0] temp_code;
  logic [DW-1:0]     span;
  logic [isfg_pkg::ACC_W:0]     xy_noise;
  logic [isfg_pkg::ACCZ_W-1:0]  z_value;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign take_word  = in_fire && (in_i.transfer_count != '0);
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // mv * (2^CODE_BITS - 1) as a shift and subtract
  assign scaled_mv = {in_i.analog_millivolts, {CODE_BITS{1'b0}}}
                   - PROD_W'(in_i.analog_millivolts);

  // divide by 5000: the /8 happens at capture, /625 by reciprocal multiply;
  // below full scale the product stays under 2^29, where this is exact
  assign temp_prod = TPROD_W'(temp_q) * TPROD_W'(isfg_pkg::TEMP_RECIP);
  assign temp_code = temp_sat_q ? FULL[CODE_BITS-1:0]
                                : temp_prod[isfg_pkg::TEMP_SHIFT +: CODE_BITS];

  // lcg step, truncated to 32 bits
  assign gen_next = gen_q * isfg_pkg::LCG_MUL + isfg_pkg::LCG_ADD;

  // modulus 2r+1 for the axis about to be drawn
  always_comb begin
    if (axis_q == AXIS_Z) begin
      span = DW'({z_range_q, 1'b1});
    end else begin
      span = DW'({xy_range_q, 1'b1});
    end
  end

  // shared divider: noise modulus of each new generator value
  always_comb begin
    div_req.start    = (state_q == S_STEP);
    div_req.dividend = gen_next;
    div_req.divisor  = span;
  end

  isfg_divider #(
    .W (DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // remainder minus r, plus one g for z; x/y remainders fit 16 bits, z remainders fit 15 bits
  assign xy_noise = {1'b0, div_rsp.remainder[isfg_pkg::ACC_W-1:0]}
                  - (isfg_pkg::ACC_W + 1)'(xy_range_q);
  assign z_value  = div_rsp.remainder[isfg_pkg::ACCZ_W-1:0] + isfg_pkg::ONE_G
                  - isfg_pkg::ACCZ_W'(z_range_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (take_word) state_d = S_TEMP;
      S_TEMP:  state_d = S_STEP;
      S_STEP:  state_d = S_NOISE;
      S_NOISE: begin
        if (div_rsp.done) begin
          state_d = (axis_q == AXIS_Z) ? S_DONE : S_STEP;
        end
      end
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= AXIS_X;
      gen_q       <= isfg_pkg::GEN_RESET;
      xy_range_q  <= isfg_pkg::XY_RANGE_RESET;
      z_range_q   <= isfg_pkg::Z_RANGE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_index_i == isfg_pkg::CFG_XY_RANGE)) begin
        xy_range_q <= cfg_data_i[isfg_pkg::XY_W-1:0];
      end
      if (cfg_we_i && (cfg_index_i == isfg_pkg::CFG_Z_RANGE)) begin
        z_range_q <= cfg_data_i[isfg_pkg::Z_W-1:0];
      end
      if (state_q == S_STEP) begin
        gen_q <= gen_next;
      end
      if (take_word) begin
        axis_q <= AXIS_X;
      end else if ((state_q == S_NOISE) && div_rsp.done) begin
        case (axis_q)
          AXIS_X:  axis_q <= AXIS_Y;
          AXIS_Y:  axis_q <= AXIS_Z;
          default: axis_q <= AXIS_X;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // reply payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take_word) begin
      temp_q     <= scaled_mv[PROD_W-1:isfg_pkg::TEMP_PRE_SHIFT];
      temp_sat_q <= (DW'(in_i.analog_millivolts) >= isfg_pkg::FULL_SCALE_MV);
    end
    if (state_q == S_TEMP) begin
      code_q <= temp_code;
    end
    if ((state_q == S_NOISE) && div_rsp.done) begin
      case (axis_q)
        AXIS_X:  x_q <= xy_noise[isfg_pkg::ACC_W-1:0];
        AXIS_Y:  y_q <= xy_noise[isfg_pkg::ACC_W-1:0];
        default: z_q <= z_value;
      endcase
    end
    if (load_out) begin
      out_code_q <= code_q;
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_z_q    <= z_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.temperature_code = out_code_q;
  assign out_o.accel_x          = out_x_q;
  assign out_o.accel_y          = out_y_q;
  assign out_o.accel_z          = out_z_q;

endmodule

>>> rtl/core/isfg_sva.sv
`include "imu_sample_frame_generator_core_assert.svh"

// port-level checks of the core
module isfg_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [isfg_pkg::COUNT_W-1:0]  in_count,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [isfg_pkg::ACC_W-1:0]    out_x,
  input logic [isfg_pkg::ACCZ_W-1:0]   out_z
);

  // reply held until taken
  `ISFG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // stalled reply keeps its value
  `ISFG_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_x) && $stable(out_z))
  // a real transfer occupies the sequencer
  `ISFG_ASSERT_NEXT(a_busy_after_word, in_valid && in_ready && (in_count != '0), !in_ready)
  // an empty transfer is dropped at once
  `ISFG_ASSERT_NEXT(a_zero_count_idle, in_valid && in_ready && (in_count == '0), in_ready)
  // z sits at one g plus bounded noise, never zero
  `ISFG_ASSERT_NOW(a_z_nonzero, out_valid, out_z != '0)

endmodule

bind imu_sample_frame_generator_core isfg_sva u_isfg_sva (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_count  (in_i.transfer_count),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_x     (out_o.accel_x),
  .out_z     (out_o.accel_z)
);
